// ===== hw/rtl/hrhv_pkg.sv =====
// ----------------------------------------------------------------------------
// hrhv_pkg
// Shared types, codes and character constants of the request head validator.
// ----------------------------------------------------------------------------
package hrhv_pkg;

  localparam int SPACE_HOLD_DEPTH = 16;
  localparam int SPACE_IDX_W = (SPACE_HOLD_DEPTH > 1) ? $clog2(SPACE_HOLD_DEPTH) : 1;
  localparam int SPACE_CNT_W = $clog2(SPACE_HOLD_DEPTH + 1);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic [2:0] VERSION_HEAD_LEN = 3'd5;
  localparam logic [2:0] VERSION_OK       = 3'd6;
  localparam logic [2:0] VERSION_BAD      = 3'd7;

  localparam logic [3:0] KIND_METHOD  = 4'd0;
  localparam logic [3:0] KIND_PATH    = 4'd1;
  localparam logic [3:0] KIND_QUERY   = 4'd2;
  localparam logic [3:0] KIND_VERSION = 4'd3;
  localparam logic [3:0] KIND_NAME    = 4'd4;
  localparam logic [3:0] KIND_VALUE   = 4'd5;
  localparam logic [3:0] KIND_HEADEND = 4'd6;
  localparam logic [3:0] KIND_BODY    = 4'd7;
  localparam logic [3:0] KIND_STATUS  = 4'd8;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_EMPTY    = 3'd1;
  localparam logic [2:0] ERR_REQLINE  = 3'd2;
  localparam logic [2:0] ERR_METHOD   = 3'd3;
  localparam logic [2:0] ERR_VERSION  = 3'd4;
  localparam logic [2:0] ERR_FORMAT   = 3'd5;
  localparam logic [2:0] ERR_NAME     = 3'd6;
  localparam logic [2:0] ERR_OVERFLOW = 3'd7;

  typedef enum logic [1:0] {
    PH_LINE = 2'd0,
    PH_HEAD = 2'd1,
    PH_BODY = 2'd2,
    PH_HALT = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_CR   = 3'd1,
    OP_MAIN = 3'd2,
    OP_FIN  = 3'd3,
    OP_STAT = 3'd4
  } op_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
    logic       no_byte;
  } req_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] part_kind;
    logic [2:0] status_code;
    logic       final_item;
  } res_word_t;

  typedef struct packed {
    logic load;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic return_held;
    logic line_active;
    logic end_of_message;
  } dp_status_t;

  // Expected bytes of the version prefix.
  function automatic logic [7:0] version_head(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h48;
      3'd1: c = 8'h54;
      3'd2: c = 8'h54;
      3'd3: c = 8'h50;
      3'd4: c = 8'h2F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/http_request_head_validator.sv =====
// ----------------------------------------------------------------------------
// http_request_head_validator
// Splits a raw request into tagged parts and reports the first format error.
// ----------------------------------------------------------------------------
// One word is taken at a time. A word carrying a byte is accepted and then
// processed, after a held carriage return is replayed when needed and after
// any held value whitespace bytes are emitted ahead of a value byte. The end
// of a request adds the closing checks and the status word.
// Every result goes through a single output register, so a stalled output
// holds the sequencer in place; the whitespace store holds 16 bytes.
module http_request_head_validator (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  hrhv_pkg::req_word_t req_word,
  output logic                res_valid,
  input  logic                res_stall,
  output hrhv_pkg::res_word_t res_word
);
  import hrhv_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  hrhv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_word  (req_word),
    .req_stall (req_stall),
    .cmd       (cmd),
    .status    (status)
  );

  hrhv_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_word  (req_word),
    .cmd       (cmd),
    .status    (status),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

endmodule

// ===== hw/rtl/hrhv_ctrl.sv =====
// ----------------------------------------------------------------------------
// hrhv_ctrl
// Sequencer: accepts a word and steps the datapath through its operations.
// ----------------------------------------------------------------------------
module hrhv_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  hrhv_pkg::req_word_t req_word,
  output logic               req_stall,
  output hrhv_pkg::dp_cmd_t  cmd,
  input  hrhv_pkg::dp_status_t status
);
  import hrhv_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CR   = 5'b00010,
    S_MAIN = 5'b00100,
    S_FIN  = 5'b01000,
    S_STAT = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.load   = accept;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_word.no_byte) begin
            state_next = req_word.end_of_message ? S_FIN : S_IDLE;
          end else if (status.return_held && status.line_active &&
                       (req_word.data_byte != CH_NL)) begin
            // A held carriage return that is not followed by a newline is
            // replayed as an ordinary byte first.
            state_next = S_CR;
          end else begin
            state_next = S_MAIN;
          end
        end
      end
      S_CR: begin
        cmd.op = OP_CR;
        if (status.done) state_next = S_MAIN;
      end
      S_MAIN: begin
        cmd.op = OP_MAIN;
        if (status.done) state_next = status.end_of_message ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        cmd.op = OP_FIN;
        if (status.done) state_next = S_STAT;
      end
      S_STAT: begin
        cmd.op = OP_STAT;
        if (status.done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/hrhv_dp.sv =====
// ----------------------------------------------------------------------------
// hrhv_dp
// Datapath: parser state, held whitespace store and the output register.
// ----------------------------------------------------------------------------
module hrhv_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  hrhv_pkg::req_word_t  req_word,
  input  hrhv_pkg::dp_cmd_t    cmd,
  output hrhv_pkg::dp_status_t status,
  output logic                 res_valid,
  input  logic                 res_stall,
  output hrhv_pkg::res_word_t  res_word
);
  import hrhv_pkg::*;

  typedef struct packed {
    phase_t                 phase;
    logic [1:0]             token_index;
    logic                   inside_token;
    logic                   method_all_upper;
    logic                   past_question_mark;
    logic [2:0]             version_prefix_count;
    logic                   return_held;
    logic                   line_has_bytes;
    logic                   colon_found;
    logic                   header_name_good;
    logic                   value_begun;
    logic [SPACE_CNT_W-1:0] space_count;
    logic [2:0]             first_error;
    logic                   any_byte_seen;
  } pstate_t;

  typedef struct packed {
    pstate_t   s;
    logic      em;
    res_word_t o;
    logic      wr;
  } step_t;

  localparam pstate_t PSTATE_RESET = '{
    phase: PH_LINE, token_index: 2'd0, inside_token: 1'b0,
    method_all_upper: 1'b1, past_question_mark: 1'b0,
    version_prefix_count: 3'd0, return_held: 1'b0, line_has_bytes: 1'b0,
    colon_found: 1'b0, header_name_good: 1'b1, value_begun: 1'b0,
    space_count: '0, first_error: ERR_NONE, any_byte_seen: 1'b0};

  function automatic logic is_white(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_name_char(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A) || b == CH_DASH || b == CH_UNDER;
  endfunction

  function automatic pstate_t raise_err(input pstate_t s, input logic [2:0] code);
    pstate_t r;
    r = s;
    if (r.first_error == ERR_NONE) r.first_error = code;
    r.phase = PH_HALT;
    return r;
  endfunction

  function automatic res_word_t mk(input logic [7:0] b, input logic [3:0] k);
    res_word_t o;
    o.out_byte    = b;
    o.part_kind   = k;
    o.status_code = ERR_NONE;
    o.final_item  = 1'b0;
    return o;
  endfunction

  function automatic step_t line_byte(input pstate_t s, input logic [7:0] b);
    step_t r;
    logic  skip;
    r    = '0;
    r.s  = s;
    skip = 1'b0;
    if (s.phase == PH_LINE) begin
      r.s.line_has_bytes = 1'b1;
      if (is_white(b)) begin
        r.s.inside_token = 1'b0;
      end else begin
        if (!s.inside_token) begin
          if (s.token_index == 2'd3) begin
            skip = 1'b1;
          end else begin
            r.s.token_index  = s.token_index + 2'd1;
            r.s.inside_token = 1'b1;
          end
        end
        if (!skip) begin
          if (r.s.token_index == 2'd1) begin
            if (!(b >= 8'h41 && b <= 8'h5A)) r.s.method_all_upper = 1'b0;
            r.em = 1'b1;
            r.o  = mk(b, KIND_METHOD);
          end else if (r.s.token_index == 2'd2) begin
            if (!s.past_question_mark && b == CH_QUEST) begin
              r.s.past_question_mark = 1'b1;
            end else begin
              r.em = 1'b1;
              r.o  = mk(b, s.past_question_mark ? KIND_QUERY : KIND_PATH);
            end
          end else begin
            if (s.version_prefix_count < VERSION_HEAD_LEN) begin
              r.s.version_prefix_count = (b == version_head(s.version_prefix_count))
                  ? s.version_prefix_count + 3'd1 : VERSION_BAD;
            end else if (s.version_prefix_count == VERSION_HEAD_LEN) begin
              r.s.version_prefix_count = VERSION_OK;
            end
            r.em = 1'b1;
            r.o  = mk(b, KIND_VERSION);
          end
        end
      end
    end else if (s.phase == PH_HEAD) begin
      if (!s.colon_found) begin
        if (b == CH_COLON) begin
          r.s.colon_found = 1'b1;
          if (!s.line_has_bytes || !s.header_name_good) r.s = raise_err(r.s, ERR_NAME);
          r.s.line_has_bytes = 1'b1;
        end else begin
          r.s.line_has_bytes = 1'b1;
          if (!is_name_char(b)) r.s.header_name_good = 1'b0;
          r.em = 1'b1;
          r.o  = mk(b, KIND_NAME);
        end
      end else begin
        r.s.line_has_bytes = 1'b1;
        if (is_white(b)) begin
          if (s.value_begun) begin
            if (s.space_count >= SPACE_CNT_W'(SPACE_HOLD_DEPTH)) begin
              r.s = raise_err(r.s, ERR_OVERFLOW);
            end else begin
              r.wr          = 1'b1;
              r.s.space_count = s.space_count + SPACE_CNT_W'(1);
            end
          end
        end else begin
          // Held whitespace has already been flushed ahead of this byte.
          r.s.value_begun = 1'b1;
          r.s.space_count = '0;
          r.em = 1'b1;
          r.o  = mk(b, KIND_VALUE);
        end
      end
    end
    return r;
  endfunction

  function automatic step_t end_line(input pstate_t s);
    step_t r;
    r   = '0;
    r.s = s;
    if (s.phase == PH_LINE) begin
      if (s.token_index != 2'd3)               r.s = raise_err(r.s, ERR_REQLINE);
      else if (!s.method_all_upper)            r.s = raise_err(r.s, ERR_METHOD);
      else if (s.version_prefix_count != VERSION_OK) r.s = raise_err(r.s, ERR_VERSION);
      else                                     r.s.phase = PH_HEAD;
    end else if (s.phase == PH_HEAD) begin
      if (!s.line_has_bytes) begin
        r.em      = 1'b1;
        r.o       = mk(8'h00, KIND_HEADEND);
        r.s.phase = PH_BODY;
      end else if (!s.colon_found) begin
        r.s = raise_err(r.s, ERR_FORMAT);
      end
    end
    r.s.line_has_bytes   = 1'b0;
    r.s.inside_token     = 1'b0;
    r.s.colon_found      = 1'b0;
    r.s.header_name_good = 1'b1;
    r.s.value_begun      = 1'b0;
    r.s.space_count      = '0;
    return r;
  endfunction

  pstate_t                ps;
  step_t                  nx;
  pstate_t                tmp;
  logic [7:0]             byte_q;
  logic                   eom_q;
  logic [7:0]             sym;
  logic [SPACE_CNT_W-1:0] fidx;
  logic [7:0]             space_store [SPACE_HOLD_DEPTH];
  logic                   out_free;
  logic                   op_active;
  logic                   need_flush;
  logic                   flushing;

  assign op_active = (cmd.op != OP_NONE);
  assign out_free  = !res_valid || !res_stall;
  assign sym       = (cmd.op == OP_CR) ? CH_CR : byte_q;

  assign need_flush = ((cmd.op == OP_CR) || (cmd.op == OP_MAIN)) &&
                      (ps.phase == PH_HEAD) && ps.colon_found && !is_white(sym) &&
                      !(cmd.op == OP_MAIN && (byte_q == CH_CR || byte_q == CH_NL));
  assign flushing   = need_flush && (fidx < ps.space_count);

  assign status.done           = op_active && out_free && !flushing;
  assign status.return_held    = ps.return_held;
  assign status.line_active    = (ps.phase == PH_LINE) || (ps.phase == PH_HEAD);
  assign status.end_of_message = eom_q;

  always_comb begin
    nx  = '0;
    nx.s = ps;
    tmp = ps;
    case (cmd.op)
      OP_CR: begin
        tmp = ps;
        tmp.return_held = 1'b0;
        nx = line_byte(tmp, CH_CR);
      end
      OP_MAIN: begin
        if (ps.phase == PH_BODY) begin
          nx.em = 1'b1;
          nx.o  = mk(byte_q, KIND_BODY);
          nx.s.line_has_bytes = (byte_q != CH_NL);
        end else if (ps.phase != PH_HALT) begin
          tmp = ps;
          tmp.return_held = (byte_q == CH_CR);
          if (byte_q == CH_NL)      nx = end_line(tmp);
          else if (byte_q == CH_CR) nx.s = tmp;
          else                      nx = line_byte(tmp, byte_q);
        end
      end
      OP_FIN: begin
        if (!ps.any_byte_seen) begin
          nx.s = raise_err(ps, ERR_EMPTY);
        end else if (ps.phase == PH_LINE ||
                     (ps.phase == PH_HEAD && (ps.line_has_bytes || ps.return_held))) begin
          tmp = ps;
          tmp.return_held = 1'b0;
          nx = end_line(tmp);
        end else if (ps.phase == PH_BODY && ps.line_has_bytes) begin
          nx.em = 1'b1;
          nx.o  = mk(CH_NL, KIND_BODY);
        end
      end
      OP_STAT: begin
        nx.s  = PSTATE_RESET;
        nx.em = 1'b1;
        nx.o.out_byte    = 8'h00;
        nx.o.part_kind   = KIND_STATUS;
        nx.o.status_code = ps.first_error;
        nx.o.final_item  = 1'b1;
      end
      default: nx.s = ps;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ps        <= PSTATE_RESET;
      fidx      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall) res_valid <= 1'b0;
      if (cmd.load && !req_word.no_byte) ps.any_byte_seen <= 1'b1;
      if (op_active && out_free) begin
        if (flushing) begin
          res_valid <= 1'b1;
          fidx      <= fidx + SPACE_CNT_W'(1);
        end else begin
          ps   <= nx.s;
          fidx <= '0;
          if (nx.em) res_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_q <= req_word.data_byte;
      eom_q  <= req_word.end_of_message;
    end
    if (op_active && out_free) begin
      if (flushing) begin
        res_word <= mk(space_store[fidx[SPACE_IDX_W-1:0]], KIND_VALUE);
      end else begin
        if (nx.em) res_word <= nx.o;
        if (nx.wr) space_store[ps.space_count[SPACE_IDX_W-1:0]] <= sym;
      end
    end
  end

endmodule

// ===== verif/hrhv_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hrhv_checker
// Watches both channels of the request head validator, predicts the tagged
// words each accepted request word should produce, and compares them in order.
// ----------------------------------------------------------------------------
module hrhv_checker
  import hrhv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_stall,
  input  req_word_t req_word,
  input  logic      res_valid,
  input  logic      res_stall,
  input  res_word_t res_word,
  output int        fail_count,
  output int        pending
);

  // Parser state, mirrored in the block's terms.
  phase_t     ph;
  int         tok_idx;
  bit         in_tok;
  bit         meth_upper;
  bit         past_q;
  logic [2:0] ver_cnt;
  bit         cr_held;
  bit         line_bytes;
  bit         colon_seen;
  bit         name_good;
  bit         val_begun;
  logic [7:0] ws_hold [SPACE_HOLD_DEPTH];
  int         ws_cnt;
  logic [2:0] first_err;
  bit         seen_byte;
  int         step_words;

  res_word_t expected_words [$];

  assign pending = expected_words.size();

  function automatic bit is_white(logic [7:0] b);
    return b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic bit is_name_char(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
           (b >= "a" && b <= "z") || b == CH_DASH || b == CH_UNDER;
  endfunction

  function automatic void push_word(logic [7:0] b, logic [3:0] k, logic [2:0] s,
                                    logic f);
    res_word_t w;
    if (step_words >= 20) return;
    w.out_byte = b; w.part_kind = k; w.status_code = s; w.final_item = f;
    expected_words.insert(expected_words.size(), w);
    step_words++;
  endfunction

  function automatic void flag_error(logic [2:0] code);
    if (first_err == ERR_NONE) first_err = code;
    ph = PH_HALT;
  endfunction

  function automatic void clear_line();
    line_bytes = 0; in_tok = 0; colon_seen = 0; name_good = 1;
    val_begun = 0; ws_cnt = 0;
  endfunction

  function automatic void clear_all();
    ph = PH_LINE; tok_idx = 0; meth_upper = 1; past_q = 0; ver_cnt = 0;
    cr_held = 0; clear_line(); first_err = ERR_NONE; seen_byte = 0;
  endfunction

  function automatic void line_char(logic [7:0] b);
    if (ph == PH_LINE) begin
      line_bytes = 1;
      if (is_white(b)) begin
        in_tok = 0;
        return;
      end
      if (!in_tok) begin
        if (tok_idx >= 3) return;
        tok_idx++;
        in_tok = 1;
      end
      if (tok_idx == 1) begin
        if (!(b >= "A" && b <= "Z")) meth_upper = 0;
        push_word(b, KIND_METHOD, ERR_NONE, 0);
      end else if (tok_idx == 2) begin
        if (!past_q && b == CH_QUEST) past_q = 1;
        else push_word(b, past_q ? KIND_QUERY : KIND_PATH, ERR_NONE, 0);
      end else begin
        if (ver_cnt < VERSION_HEAD_LEN) begin
          logic [7:0] want;
          case (ver_cnt)
            3'd0: want = "H";
            3'd1: want = "T";
            3'd2: want = "T";
            3'd3: want = "P";
            default: want = "/";
          endcase
          ver_cnt = (b == want) ? ver_cnt + 3'd1 : VERSION_BAD;
        end else if (ver_cnt == VERSION_HEAD_LEN) begin
          ver_cnt = VERSION_OK;
        end
        push_word(b, KIND_VERSION, ERR_NONE, 0);
      end
      return;
    end
    if (ph != PH_HEAD) return;
    if (!colon_seen) begin
      if (b == CH_COLON) begin
        colon_seen = 1;
        if (!line_bytes || !name_good) flag_error(ERR_NAME);
        line_bytes = 1;
        return;
      end
      line_bytes = 1;
      if (!is_name_char(b)) name_good = 0;
      push_word(b, KIND_NAME, ERR_NONE, 0);
      return;
    end
    line_bytes = 1;
    if (is_white(b)) begin
      if (!val_begun) return;
      if (ws_cnt >= SPACE_HOLD_DEPTH) begin
        flag_error(ERR_OVERFLOW);
        return;
      end
      ws_hold[ws_cnt] = b;
      ws_cnt++;
      return;
    end
    val_begun = 1;
    for (int i = 0; i < ws_cnt; i++) push_word(ws_hold[i], KIND_VALUE, ERR_NONE, 0);
    ws_cnt = 0;
    push_word(b, KIND_VALUE, ERR_NONE, 0);
  endfunction

  function automatic void close_line();
    if (ph == PH_LINE) begin
      if (tok_idx < 3) flag_error(ERR_REQLINE);
      else if (!meth_upper) flag_error(ERR_METHOD);
      else if (ver_cnt != VERSION_OK) flag_error(ERR_VERSION);
      else ph = PH_HEAD;
    end else if (ph == PH_HEAD) begin
      if (!line_bytes) begin
        push_word(8'h00, KIND_HEADEND, ERR_NONE, 0);
        ph = PH_BODY;
      end else if (!colon_seen) begin
        flag_error(ERR_FORMAT);
      end
    end
    clear_line();
  endfunction

  function automatic void take_char(logic [7:0] b);
    if (ph == PH_BODY) begin
      push_word(b, KIND_BODY, ERR_NONE, 0);
      line_bytes = (b != CH_NL);
      return;
    end
    if (ph == PH_HALT) return;
    if (cr_held) begin
      cr_held = 0;
      if (b == CH_NL) begin
        close_line();
        return;
      end
      line_char(CH_CR);
      if (ph == PH_HALT) return;
    end
    if (b == CH_CR) cr_held = 1;
    else if (b == CH_NL) close_line();
    else line_char(b);
  endfunction

  function automatic void predict_request_word(req_word_t w);
    step_words = 0;
    if (!w.no_byte) begin
      seen_byte = 1;
      take_char(w.data_byte);
    end
    if (w.end_of_message) begin
      if (!seen_byte) begin
        flag_error(ERR_EMPTY);
      end else if (ph == PH_LINE) begin
        cr_held = 0;
        close_line();
      end else if (ph == PH_HEAD) begin
        if (line_bytes || cr_held) begin
          cr_held = 0;
          close_line();
        end
      end else if (ph == PH_BODY) begin
        if (line_bytes) push_word(CH_NL, KIND_BODY, ERR_NONE, 0);
      end
      push_word(8'h00, KIND_STATUS, first_err, 1);
      clear_all();
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_all();
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (req_valid && !req_stall) predict_request_word(req_word);
      if (res_valid && !res_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %h", $time, res_word);
          fail_count <= fail_count + 1;
        end else begin
          res_word_t e;
          e = expected_words.pop_front();
          if (e !== res_word) begin
            $display("%0t: expected %h/%0d/%0d/%0d actual %h/%0d/%0d/%0d",
                     $time, e.out_byte, e.part_kind, e.status_code, e.final_item,
                     res_word.out_byte, res_word.part_kind, res_word.status_code,
                     res_word.final_item);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_http_request_head_validator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_http_request_head_validator
// Drives directed and random requests, well-formed and broken, into the
// validator under varying idle and stall patterns; the checker compares.
// ----------------------------------------------------------------------------
module tb_http_request_head_validator;
  import hrhv_pkg::*;

  logic      clk = 0;
  logic      rst = 1;
  logic      req_valid = 0;
  logic      req_stall;
  req_word_t req_word = '0;
  logic      res_valid;
  logic      res_stall = 0;
  res_word_t res_word;
  int        fail_count;
  int        pending;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        sent;

  always #5 clk = ~clk;

  http_request_head_validator dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
    .res_valid(res_valid), .res_stall(res_stall), .res_word(res_word)
  );

  hrhv_checker chk (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
    .res_valid(res_valid), .res_stall(res_stall), .res_word(res_word),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (!rst) res_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Sends one word; valid stays high across back-to-back words.
  task automatic send_word(logic [7:0] b, logic eom, logic nob);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 0;
      @(posedge clk);
    end
    req_valid <= 1;
    req_word <= '{data_byte: b, end_of_message: eom, no_byte: nob};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_text(string s, bit close);
    for (int i = 0; i < s.len(); i++)
      send_word(s[i], close && i == s.len() - 1, 0);
  endtask

  function automatic string rand_tok(int n, int lo, int hi);
    string s = "";
    for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(hi, lo)))};
    return s;
  endfunction

  function automatic string pick(string a, string b, int pct);
    return ($urandom_range(99) < pct) ? a : b;
  endfunction

  // Mostly valid requests with random content, with occasional defects.
  function automatic string rand_request();
    string s, nl;
    nl = pick("\r\n", "\n", 60);
    s = {pick(rand_tok($urandom_range(3, 1), "A", "Z"), rand_tok(2, "a", "z"), 90), " ",
         "/", rand_tok($urandom_range(3), "a", "z"),
         pick({"?", rand_tok($urandom_range(3), "a", "z"), "?x"}, "", 40),
         pick(" HTTP/1.1", pick(" HTTP", "", 50), 88), nl};
    for (int h = $urandom_range(2); h > 0; h--)
      s = {s, pick(rand_tok($urandom_range(3, 1), "a", "z"),
                   rand_tok(2, 32, 126), 88),
           pick(": ", pick(" ", "::", 50), 90),
           rand_tok($urandom_range(2, 1), "a", "z"),
           pick(pick("  \t ", "                  ", 80), "", 30),
           rand_tok(1, "0", "9"), pick(" ", "", 50), nl};
    if ($urandom_range(99) < 70) s = {s, nl, rand_tok($urandom_range(4), 0, 255)};
    if ($urandom_range(99) < 10) s = {s, rand_tok(3, 0, 255)};
    return s;
  endfunction

  initial begin
    string r;
    sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: empty request, a clean one, and each error class.
    send_word(8'h00, 1, 1);
    send_word(8'h41, 0, 1);
    send_text("GET /a?b HTTP/1.1\r\nX-y_1: v \t w  \r\n\r\nhi", 1);
    send_text("get / HTTP/1.0\n\n", 1);
    send_text("GET /\n", 1);
    send_text("GET / HTTQ/1\n", 1);
    send_text("GET / H a\r\nBad@:x\n", 1);
    send_text("GET / HTTP/1 x\nnocolon\n", 1);
    send_text("GET / HTTP/1\n:v\n", 1);
    send_text("P / HTTP/1\na:b                  c\n", 1);
    send_text("P / HTTP/1\r\n\r", 1);
    send_text("P /\r HTTP/1\r\n\n\r\xff\x00", 1);
    for (int phase_no = 0; phase_no < 3; phase_no++) begin
      send_idle_pct  = (phase_no == 0) ? 14 : (phase_no == 1) ? 52 : 0;
      recv_stall_pct = (phase_no == 0) ? 52 : (phase_no == 1) ? 14 : 0;
      for (int n = sent + 80; sent < n; ) begin
        r = rand_request();
        if ($urandom_range(99) < 4) send_word(8'h00, 1, 1);
        else send_text(r, 1);
      end
    end
    req_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/hrhv_pkg.sv
hw/rtl/hrhv_ctrl.sv
hw/rtl/hrhv_dp.sv
hw/rtl/http_request_head_validator.sv
verif/hrhv_checker.sv
verif/tb_http_request_head_validator.sv
